// ----- rtl/tlmt_pkg.sv -----
package tlmt_pkg;

  localparam int TRIE_ENTRIES = 4096;
  localparam int TRIE_AW      = $clog2(TRIE_ENTRIES);
  localparam int TABLE_BYTES  = 4096;
  localparam int TABLE_AW     = $clog2(TABLE_BYTES);
  localparam int TEXT_BYTES   = 256;
  localparam int TEXT_AW      = $clog2(TEXT_BYTES);
  localparam int TLEN_W       = TEXT_AW + 1;
  localparam int PIECE_BYTES  = 32;
  localparam int CNT_W        = $clog2(PIECE_BYTES + 1);

  localparam int OPC_W   = 3;
  localparam int ADDR_W  = 12;
  localparam int BASE_W  = 14;
  localparam int CHECK_W = 13;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 13;
  localparam int LEN_W   = 14;
  localparam int TADDR_W = 15;
  localparam int ADV_W   = 11;
  localparam int NODE_W  = BASE_W + CHECK_W;

  localparam logic [CHECK_W-1:0] UNUSED_CHECK = '1;

  typedef enum logic [OPC_W-1:0] {
    OPC_NODE    = 3'd0,
    OPC_TABLE   = 3'd1,
    OPC_APPEND  = 3'd2,
    OPC_CONVERT = 3'd3,
    OPC_CLEAR   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_TRUNC  = 2'd2,
    ERR_REWIND = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT,
    ST_TERM_RD,
    ST_TERM,
    ST_CHILD,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_REW_RD,
    ST_REW,
    ST_LEAD_RD,
    ST_LEAD,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_STATUS,
    ST_EMIT_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_ROOT_RD,
    OP_ROOT,
    OP_TERM_RD,
    OP_TERM,
    OP_CHILD,
    OP_DECIDE,
    OP_SCAN_RD,
    OP_SCAN,
    OP_REW_RD,
    OP_REW,
    OP_LEAD_RD,
    OP_LEAD,
    OP_EMIT_RD,
    OP_EMIT_LD,
    OP_STATUS_LD,
    OP_EMIT_ACK
  } dp_op_t;

  typedef struct packed {
    logic rp_done;
    logic b_bad;
    logic at_end;
    logic p_bad;
    logic child_ok;
    logic match_found;
    logic scan_more;
    logic len_zero;
    logic out_last;
    logic clear_done;
  } dp_status_t;

  typedef struct packed {
    logic [CHECK_W-1:0]       check;
    logic signed [BASE_W-1:0] base;
  } node_t;

endpackage

// ----- rtl/trie_longest_match_transliterator_top.sv -----
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_opcode, in_address, in_base_value,
//         |           | in_check_value, in_data
// out     | output    | out_valid, out_stall, out_out_byte, out_byte_valid, out_last,
//         |           | out_text_done, out_error
//
// Load and clear words are taken in the idle state; a convert word on a consumed text
// gives one status word. Any other convert word walks the trie through the single read
// port of the node memory, then scans the table string serially on a match or takes the
// leading text character otherwise. An empty piece gives one status word in place of the
// emitted bytes. After reset a clearing pass writes all 4096 node entries while in_stall
// stays high. Each result word waits in the output register while out_stall is high.
module trie_longest_match_transliterator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tlmt_pkg::OPC_W-1:0]          in_opcode,
  input  logic [tlmt_pkg::ADDR_W-1:0]         in_address,
  input  logic signed [tlmt_pkg::BASE_W-1:0]  in_base_value,
  input  logic [tlmt_pkg::CHECK_W-1:0]        in_check_value,
  input  logic [tlmt_pkg::BYTE_W-1:0]         in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tlmt_pkg::BYTE_W-1:0]         out_out_byte,
  output logic                                out_byte_valid,
  output logic                                out_last,
  output logic                                out_text_done,
  output logic [1:0]                          out_error
);

  tlmt_pkg::dp_op_t     op;
  tlmt_pkg::dp_status_t status;

  tlmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .out_stall (out_stall),
    .status    (status),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  tlmt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_base_value  (in_base_value),
    .in_check_value (in_check_value),
    .in_data        (in_data),
    .status         (status),
    .out_out_byte   (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_text_done  (out_text_done),
    .out_error      (out_error)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("Input taken while a result word is pending.");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last)
    else $error("Status-only word is not the last word.");

  a_error_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_error == 2'd0)
    else $error("Error code on a word other than the last.");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |=> !out_valid && !in_stall)
    else $error("Block did not return to idle after the last word.");

endmodule

// ----- rtl/tlmt_ram.sv -----
module tlmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tlmt_ctrl.sv -----
module tlmt_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [tlmt_pkg::OPC_W-1:0]       in_opcode,
  input  logic                             out_stall,
  input  tlmt_pkg::dp_status_t             status,
  output tlmt_pkg::dp_op_t                 op,
  output logic                             in_stall,
  output logic                             out_valid
);

  tlmt_pkg::state_t state_r;
  tlmt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlmt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlmt_pkg::ST_CLEAR: begin
        if (status.clear_done) state_nxt = tlmt_pkg::ST_IDLE;
      end
      tlmt_pkg::ST_IDLE: begin
        if (in_valid && (in_opcode == tlmt_pkg::OPC_CONVERT)) begin
          state_nxt = status.rp_done ? tlmt_pkg::ST_STATUS : tlmt_pkg::ST_ROOT_RD;
        end
      end
      tlmt_pkg::ST_ROOT_RD: state_nxt = tlmt_pkg::ST_ROOT;
      tlmt_pkg::ST_ROOT:    state_nxt = tlmt_pkg::ST_TERM_RD;
      tlmt_pkg::ST_TERM_RD: begin
        state_nxt = status.b_bad ? tlmt_pkg::ST_DECIDE : tlmt_pkg::ST_TERM;
      end
      tlmt_pkg::ST_TERM: begin
        if (status.at_end || status.p_bad) state_nxt = tlmt_pkg::ST_DECIDE;
        else state_nxt = tlmt_pkg::ST_CHILD;
      end
      tlmt_pkg::ST_CHILD: begin
        state_nxt = status.child_ok ? tlmt_pkg::ST_TERM_RD : tlmt_pkg::ST_DECIDE;
      end
      tlmt_pkg::ST_DECIDE: begin
        state_nxt = status.match_found ? tlmt_pkg::ST_SCAN_RD : tlmt_pkg::ST_LEAD_RD;
      end
      tlmt_pkg::ST_SCAN_RD: state_nxt = tlmt_pkg::ST_SCAN;
      tlmt_pkg::ST_SCAN: begin
        state_nxt = status.scan_more ? tlmt_pkg::ST_SCAN_RD : tlmt_pkg::ST_REW_RD;
      end
      tlmt_pkg::ST_REW_RD:  state_nxt = tlmt_pkg::ST_REW;
      tlmt_pkg::ST_REW: begin
        state_nxt = status.len_zero ? tlmt_pkg::ST_STATUS : tlmt_pkg::ST_EMIT_RD;
      end
      tlmt_pkg::ST_LEAD_RD: state_nxt = tlmt_pkg::ST_LEAD;
      tlmt_pkg::ST_LEAD:    state_nxt = tlmt_pkg::ST_EMIT_RD;
      tlmt_pkg::ST_EMIT_RD: state_nxt = tlmt_pkg::ST_EMIT_LD;
      tlmt_pkg::ST_EMIT_LD: state_nxt = tlmt_pkg::ST_EMIT_OUT;
      tlmt_pkg::ST_STATUS:  state_nxt = tlmt_pkg::ST_EMIT_OUT;
      tlmt_pkg::ST_EMIT_OUT: begin
        if (!out_stall) begin
          state_nxt = status.out_last ? tlmt_pkg::ST_IDLE : tlmt_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = tlmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op        = tlmt_pkg::OP_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      tlmt_pkg::ST_CLEAR: op = tlmt_pkg::OP_CLEAR;
      tlmt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = tlmt_pkg::OP_ACCEPT;
      end
      tlmt_pkg::ST_ROOT_RD: op = tlmt_pkg::OP_ROOT_RD;
      tlmt_pkg::ST_ROOT:    op = tlmt_pkg::OP_ROOT;
      tlmt_pkg::ST_TERM_RD: op = tlmt_pkg::OP_TERM_RD;
      tlmt_pkg::ST_TERM:    op = tlmt_pkg::OP_TERM;
      tlmt_pkg::ST_CHILD:   op = tlmt_pkg::OP_CHILD;
      tlmt_pkg::ST_DECIDE:  op = tlmt_pkg::OP_DECIDE;
      tlmt_pkg::ST_SCAN_RD: op = tlmt_pkg::OP_SCAN_RD;
      tlmt_pkg::ST_SCAN:    op = tlmt_pkg::OP_SCAN;
      tlmt_pkg::ST_REW_RD:  op = tlmt_pkg::OP_REW_RD;
      tlmt_pkg::ST_REW:     op = tlmt_pkg::OP_REW;
      tlmt_pkg::ST_LEAD_RD: op = tlmt_pkg::OP_LEAD_RD;
      tlmt_pkg::ST_LEAD:    op = tlmt_pkg::OP_LEAD;
      tlmt_pkg::ST_EMIT_RD: op = tlmt_pkg::OP_EMIT_RD;
      tlmt_pkg::ST_EMIT_LD: op = tlmt_pkg::OP_EMIT_LD;
      tlmt_pkg::ST_STATUS:  op = tlmt_pkg::OP_STATUS_LD;
      tlmt_pkg::ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) op = tlmt_pkg::OP_EMIT_ACK;
      end
      default: op = tlmt_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/tlmt_datapath.sv -----
module tlmt_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlmt_pkg::dp_op_t                    op,
  input  logic [tlmt_pkg::OPC_W-1:0]          in_opcode,
  input  logic [tlmt_pkg::ADDR_W-1:0]         in_address,
  input  logic signed [tlmt_pkg::BASE_W-1:0]  in_base_value,
  input  logic [tlmt_pkg::CHECK_W-1:0]        in_check_value,
  input  logic [tlmt_pkg::BYTE_W-1:0]         in_data,
  output tlmt_pkg::dp_status_t                status,
  output logic [tlmt_pkg::BYTE_W-1:0]         out_out_byte,
  output logic                                out_byte_valid,
  output logic                                out_last,
  output logic                                out_text_done,
  output logic [1:0]                          out_error
);

  localparam int TRIE_AW = tlmt_pkg::TRIE_AW;
  localparam int TEXT_AW = tlmt_pkg::TEXT_AW;
  localparam int TLEN_W  = tlmt_pkg::TLEN_W;
  localparam int CNT_W   = tlmt_pkg::CNT_W;
  localparam int BASE_W  = tlmt_pkg::BASE_W;
  localparam int CHECK_W = tlmt_pkg::CHECK_W;
  localparam int BYTE_W  = tlmt_pkg::BYTE_W;
  localparam int IDX_W   = tlmt_pkg::IDX_W;
  localparam int LEN_W   = tlmt_pkg::LEN_W;
  localparam int TADDR_W = tlmt_pkg::TADDR_W;
  localparam int ADV_W   = tlmt_pkg::ADV_W;

  logic [TLEN_W-1:0]        tlen_r, tlen_nxt, rp_r, rp_nxt, newrp_r, newrp_nxt;
  logic [TRIE_AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic signed [BASE_W-1:0] b_r, b_nxt;
  logic [TLEN_W-1:0]        depth_r, depth_nxt, best_depth_r, best_depth_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  tlmt_pkg::err_t           err_r, err_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     done_r, done_nxt, match_r, match_nxt, tbl_rng_r, tbl_rng_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, i_r, i_nxt;
  logic [BYTE_W-1:0]        obyte_r, obyte_nxt;
  logic                     obv_r, obv_nxt, olast_r, olast_nxt, odone_r, odone_nxt;
  tlmt_pkg::err_t           oerr_r, oerr_nxt;

  logic                     node_we, tbl_we, text_we;
  logic [TRIE_AW-1:0]       node_waddr, node_raddr;
  tlmt_pkg::node_t          node_wdata, node_rd;
  logic [tlmt_pkg::NODE_W-1:0] node_rbits;
  logic [TEXT_AW-1:0]       text_raddr;
  logic [BYTE_W-1:0]        text_rdata, tbl_rdata, tbl_byte;
  logic [TADDR_W-1:0]       tbl_addr_x;
  logic [TLEN_W-1:0]        remaining;
  logic [BASE_W-1:0]        b_u;
  logic [CHECK_W-1:0]       b_chk;
  logic [TADDR_W-1:0]       p_sum;
  logic                     terminal, is_convert;
  logic [ADV_W-1:0]         adv, adv_fix;
  logic                     adv_lt1;
  logic [2:0]               cl;
  logic [TLEN_W-1:0]        cl_ext;

  assign node_rd   = tlmt_pkg::node_t'(node_rbits);
  assign remaining = tlen_r - rp_r;
  assign b_u       = b_r;
  assign b_chk     = CHECK_W'(b_u);
  assign p_sum     = TADDR_W'(b_u) + TADDR_W'(text_rdata) + TADDR_W'(1);
  assign terminal  = (node_rd.check == b_chk) && node_rd.base[BASE_W-1];
  assign tbl_byte  = tbl_rng_r ? tbl_rdata : '0;
  assign is_convert = (in_opcode == tlmt_pkg::OPC_CONVERT);

  assign adv     = ADV_W'({2'b00, best_depth_r}) - ADV_W'($signed(tbl_byte));
  assign adv_lt1 = adv[ADV_W-1] || (adv == '0);
  assign adv_fix = adv_lt1 ? ADV_W'(1) : adv;

  always_comb begin
    if (text_rdata >= 8'hC0 && text_rdata <= 8'hDF) cl = 3'd2;
    else if (text_rdata >= 8'hE0 && text_rdata <= 8'hEF) cl = 3'd3;
    else if (text_rdata >= 8'hF0 && text_rdata <= 8'hF7) cl = 3'd4;
    else cl = 3'd1;
  end
  assign cl_ext = TLEN_W'(cl);

  always_comb begin
    status.rp_done     = rp_r >= tlen_r;
    status.b_bad       = b_r[BASE_W-1] || (b_u >= BASE_W'(tlmt_pkg::TRIE_ENTRIES));
    status.at_end      = depth_r >= remaining;
    status.p_bad       = p_sum >= TADDR_W'(tlmt_pkg::TRIE_ENTRIES);
    status.child_ok    = node_rd.check == b_chk;
    status.match_found = best_depth_r != '0;
    status.scan_more   = tbl_byte != '0;
    status.len_zero    = len_r == '0;
    status.out_last    = olast_r;
    status.clear_done  = clr_cnt_r == TRIE_AW'(tlmt_pkg::TRIE_ENTRIES - 1);
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = in_address[TRIE_AW-1:0];
    node_wdata.base  = in_base_value;
    node_wdata.check = in_check_value;
    tbl_we     = 1'b0;
    text_we    = 1'b0;
    node_raddr = '0;
    text_raddr = TEXT_AW'(rp_r);
    tbl_addr_x = TADDR_W'(best_idx_r) + TADDR_W'(i_r);
    case (op)
      tlmt_pkg::OP_CLEAR: begin
        node_we          = 1'b1;
        node_waddr       = clr_cnt_r;
        node_wdata.base  = '0;
        node_wdata.check = tlmt_pkg::UNUSED_CHECK;
      end
      tlmt_pkg::OP_ACCEPT: begin
        node_we = (in_opcode == tlmt_pkg::OPC_NODE) &&
                  (32'(in_address) < tlmt_pkg::TRIE_ENTRIES);
        tbl_we  = (in_opcode == tlmt_pkg::OPC_TABLE) &&
                  (32'(in_address) < tlmt_pkg::TABLE_BYTES);
        text_we = (in_opcode == tlmt_pkg::OPC_APPEND) &&
                  (tlen_r < TLEN_W'(tlmt_pkg::TEXT_BYTES));
      end
      tlmt_pkg::OP_TERM_RD: begin
        node_raddr = b_r[TRIE_AW-1:0];
        text_raddr = TEXT_AW'(rp_r + depth_r);
      end
      tlmt_pkg::OP_TERM:    node_raddr = p_sum[TRIE_AW-1:0];
      tlmt_pkg::OP_SCAN_RD: tbl_addr_x = TADDR_W'(best_idx_r) + TADDR_W'(len_r);
      tlmt_pkg::OP_REW_RD: begin
        tbl_addr_x = TADDR_W'(best_idx_r) + TADDR_W'(len_r) + TADDR_W'(1);
      end
      tlmt_pkg::OP_EMIT_RD: text_raddr = TEXT_AW'(rp_r + TLEN_W'(i_r));
      default: node_raddr = '0;
    endcase
  end

  assign tbl_rng_nxt = tbl_addr_x < TADDR_W'(tlmt_pkg::TABLE_BYTES);

  always_comb begin
    tlen_nxt       = tlen_r;
    rp_nxt         = rp_r;
    newrp_nxt      = newrp_r;
    clr_cnt_nxt    = clr_cnt_r;
    b_nxt          = b_r;
    depth_nxt      = depth_r;
    best_depth_nxt = best_depth_r;
    best_idx_nxt   = best_idx_r;
    err_nxt        = err_r;
    len_nxt        = len_r;
    done_nxt       = done_r;
    match_nxt      = match_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    obyte_nxt      = obyte_r;
    obv_nxt        = obv_r;
    olast_nxt      = olast_r;
    odone_nxt      = odone_r;
    oerr_nxt       = oerr_r;
    case (op)
      tlmt_pkg::OP_CLEAR: clr_cnt_nxt = clr_cnt_r + TRIE_AW'(1);
      tlmt_pkg::OP_ACCEPT: begin
        if (text_we) tlen_nxt = tlen_r + TLEN_W'(1);
        if (in_opcode == tlmt_pkg::OPC_CLEAR) begin
          tlen_nxt = '0;
          rp_nxt   = '0;
        end
        if (is_convert) begin
          depth_nxt      = '0;
          best_depth_nxt = '0;
          err_nxt        = tlmt_pkg::ERR_NONE;
          done_nxt       = 1'b1;
          newrp_nxt      = rp_r;
        end
      end
      tlmt_pkg::OP_ROOT: b_nxt = node_rd.base;
      tlmt_pkg::OP_TERM_RD: begin
        if (status.b_bad) err_nxt = tlmt_pkg::ERR_RANGE;
      end
      tlmt_pkg::OP_TERM: begin
        if (terminal) begin
          best_depth_nxt = depth_r;
          best_idx_nxt   = IDX_W'(~node_rd.base);
        end
        if (!status.at_end && status.p_bad) err_nxt = tlmt_pkg::ERR_RANGE;
      end
      tlmt_pkg::OP_CHILD: begin
        if (status.child_ok) begin
          b_nxt     = node_rd.base;
          depth_nxt = depth_r + TLEN_W'(1);
        end
      end
      tlmt_pkg::OP_DECIDE: begin
        len_nxt   = '0;
        match_nxt = status.match_found;
      end
      tlmt_pkg::OP_SCAN: begin
        if (status.scan_more) len_nxt = len_r + LEN_W'(1);
      end
      tlmt_pkg::OP_REW: begin
        if (len_r > LEN_W'(tlmt_pkg::PIECE_BYTES) && err_r < tlmt_pkg::ERR_TRUNC) begin
          err_nxt = tlmt_pkg::ERR_TRUNC;
        end
        if (adv_lt1) err_nxt = tlmt_pkg::ERR_REWIND;
        if (adv_fix >= ADV_W'(remaining)) newrp_nxt = tlen_r;
        else newrp_nxt = rp_r + TLEN_W'(adv_fix);
        done_nxt = (adv_fix >= ADV_W'(remaining)) ||
                   ((rp_r + TLEN_W'(adv_fix)) >= tlen_r);
        cnt_nxt  = (len_r > LEN_W'(tlmt_pkg::PIECE_BYTES)) ?
                   CNT_W'(tlmt_pkg::PIECE_BYTES) : CNT_W'(len_r);
        i_nxt    = '0;
      end
      tlmt_pkg::OP_LEAD: begin
        if (cl_ext >= remaining) begin
          newrp_nxt = tlen_r;
          cnt_nxt   = CNT_W'(remaining);
        end else begin
          newrp_nxt = rp_r + cl_ext;
          cnt_nxt   = CNT_W'(cl);
        end
        done_nxt = (cl_ext >= remaining) || ((rp_r + cl_ext) >= tlen_r);
        i_nxt    = '0;
      end
      tlmt_pkg::OP_EMIT_LD: begin
        obyte_nxt = match_r ? tbl_byte : text_rdata;
        obv_nxt   = 1'b1;
        olast_nxt = (i_r + CNT_W'(1)) == cnt_r;
        odone_nxt = done_r;
        oerr_nxt  = ((i_r + CNT_W'(1)) == cnt_r) ? err_r : tlmt_pkg::ERR_NONE;
      end
      tlmt_pkg::OP_STATUS_LD: begin
        obyte_nxt = '0;
        obv_nxt   = 1'b0;
        olast_nxt = 1'b1;
        odone_nxt = done_r;
        oerr_nxt  = err_r;
      end
      tlmt_pkg::OP_EMIT_ACK: begin
        i_nxt = i_r + CNT_W'(1);
        if (olast_r) rp_nxt = newrp_r;
      end
      default: i_nxt = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r    <= '0;
      rp_r      <= '0;
      clr_cnt_r <= '0;
    end else begin
      tlen_r    <= tlen_nxt;
      rp_r      <= rp_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newrp_r      <= newrp_nxt;
    b_r          <= b_nxt;
    depth_r      <= depth_nxt;
    best_depth_r <= best_depth_nxt;
    best_idx_r   <= best_idx_nxt;
    err_r        <= err_nxt;
    len_r        <= len_nxt;
    done_r       <= done_nxt;
    match_r      <= match_nxt;
    tbl_rng_r    <= tbl_rng_nxt;
    cnt_r        <= cnt_nxt;
    i_r          <= i_nxt;
    obyte_r      <= obyte_nxt;
    obv_r        <= obv_nxt;
    olast_r      <= olast_nxt;
    odone_r      <= odone_nxt;
    oerr_r       <= oerr_nxt;
  end

  tlmt_ram #(
    .WIDTH (tlmt_pkg::NODE_W),
    .DEPTH (tlmt_pkg::TRIE_ENTRIES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rbits)
  );

  tlmt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (tlmt_pkg::TABLE_BYTES)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_address[tlmt_pkg::TABLE_AW-1:0]),
    .wdata (in_data),
    .raddr (tbl_addr_x[tlmt_pkg::TABLE_AW-1:0]),
    .rdata (tbl_rdata)
  );

  tlmt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (tlmt_pkg::TEXT_BYTES)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (tlen_r[TEXT_AW-1:0]),
    .wdata (in_data),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  assign out_out_byte   = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;
  assign out_text_done  = odone_r;
  assign out_error      = oerr_r;

endmodule

// ----- verif/trie_longest_match_transliterator_checker.sv -----
`timescale 1ns / 100ps

module trie_longest_match_transliterator_checker
  import tlmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OPC_W-1:0]          in_opcode,
  input  logic [ADDR_W-1:0]         in_address,
  input  logic signed [BASE_W-1:0]  in_base_value,
  input  logic [CHECK_W-1:0]        in_check_value,
  input  logic [BYTE_W-1:0]         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [BYTE_W-1:0]         out_out_byte,
  input  logic                      out_byte_valid,
  input  logic                      out_last,
  input  logic                      out_text_done,
  input  logic [1:0]                out_error,
  output int                        fail_count,
  output int                        open_count
);

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              has_byte;
    logic              last;
    logic              done;
    logic [1:0]        err;
  } result_word_t;

  logic signed [BASE_W-1:0] trie_base [TRIE_ENTRIES];
  logic [CHECK_W-1:0]       trie_check [TRIE_ENTRIES];
  logic [BYTE_W-1:0]        piece_mem [TABLE_BYTES];
  logic [BYTE_W-1:0]        text_mem [TEXT_BYTES];
  int unsigned              text_len;
  int unsigned              read_pos;
  result_word_t             due_words [$];

  initial begin
    fail_count = 0;
    open_count = 0;
    text_len = 0;
    read_pos = 0;
    for (int i = 0; i < TRIE_ENTRIES; i++) begin
      trie_base[i] = '0;
      trie_check[i] = UNUSED_CHECK;
    end
    for (int i = 0; i < TABLE_BYTES; i++) piece_mem[i] = '0;
    for (int i = 0; i < TEXT_BYTES; i++) text_mem[i] = '0;
  end

  function automatic logic [BYTE_W-1:0] piece_byte(int unsigned a);
    return (a < TABLE_BYTES) ? piece_mem[a] : '0;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Walks the trie from the read position and queues the words of one convert step.
  task automatic predict_convert();
    result_word_t words [$];
    result_word_t w;
    int unsigned  remain, depth, best_depth, best_idx, len, clen, p;
    int           b, nb, adv, rw;
    logic [1:0]   err;
    err = ERR_NONE;
    if (read_pos >= text_len) begin
      w = '{value: '0, has_byte: 1'b0, last: 1'b1, done: 1'b1, err: ERR_NONE};
      due_words.push_back(w);
      return;
    end
    remain = text_len - read_pos;
    best_depth = 0;
    best_idx = 0;
    depth = 0;
    b = trie_base[0];
    forever begin
      if (b < 0 || b >= TRIE_ENTRIES) begin
        err = ERR_RANGE;
        break;
      end
      nb = trie_base[b];
      if (int'(trie_check[b]) == b && nb < 0) begin
        best_depth = depth;
        best_idx = -nb - 1;
      end
      if (depth >= remain) break;
      p = b + text_mem[read_pos + depth] + 1;
      if (p >= TRIE_ENTRIES) begin
        err = ERR_RANGE;
        break;
      end
      if (int'(trie_check[p]) != b) break;
      b = trie_base[p];
      depth++;
    end
    w.last = 1'b0;
    w.done = 1'b0;
    w.err = ERR_NONE;
    w.has_byte = 1'b1;
    if (best_depth > 0) begin
      len = 0;
      while (piece_byte(best_idx + len) != 0) len++;
      for (int unsigned i = 0; i < len && i < PIECE_BYTES; i++) begin
        w.value = piece_byte(best_idx + i);
        words.push_back(w);
      end
      if (len > PIECE_BYTES && err < ERR_TRUNC) err = ERR_TRUNC;
      rw = $signed(piece_byte(best_idx + len + 1));
      adv = int'(best_depth) - rw;
      if (adv < 1) begin
        adv = 1;
        err = ERR_REWIND;
      end
    end else begin
      if (text_mem[read_pos] >= 8'hC0 && text_mem[read_pos] <= 8'hDF) clen = 2;
      else if (text_mem[read_pos] >= 8'hE0 && text_mem[read_pos] <= 8'hEF) clen = 3;
      else if (text_mem[read_pos] >= 8'hF0 && text_mem[read_pos] <= 8'hF7) clen = 4;
      else clen = 1;
      for (int unsigned i = 0; i < clen && i < remain; i++) begin
        w.value = text_mem[read_pos + i];
        words.push_back(w);
      end
      adv = clen;
    end
    if (words.size() == 0) begin
      w.value = '0;
      w.has_byte = 1'b0;
      words.push_back(w);
    end
    if (adv >= remain) read_pos = text_len;
    else read_pos += adv;
    foreach (words[i]) words[i].done = (read_pos >= text_len);
    words[words.size() - 1].last = 1'b1;
    words[words.size() - 1].err = err;
    foreach (words[i]) due_words.push_back(words[i]);
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && in_valid && !in_stall) begin
      case (in_opcode)
        OPC_NODE: begin
          trie_base[in_address] = in_base_value;
          trie_check[in_address] = in_check_value;
        end
        OPC_TABLE: piece_mem[in_address] = in_data;
        OPC_APPEND: begin
          if (text_len < TEXT_BYTES) begin
            text_mem[text_len] = in_data;
            text_len++;
          end
        end
        OPC_CONVERT: predict_convert();
        OPC_CLEAR: begin
          text_len = 0;
          read_pos = 0;
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = due_words.pop_front();
        if (out_out_byte !== want.value)
          report($sformatf("out_byte %0h, expected %0h", out_out_byte, want.value));
        if (out_byte_valid !== want.has_byte)
          report($sformatf("byte_valid %0b, expected %0b", out_byte_valid, want.has_byte));
        if (out_last !== want.last)
          report($sformatf("last %0b, expected %0b", out_last, want.last));
        if (out_text_done !== want.done)
          report($sformatf("text_done %0b, expected %0b", out_text_done, want.done));
        if (out_error !== want.err)
          report($sformatf("error %0d, expected %0d", out_error, want.err));
      end
    end
    open_count = due_words.size();
  end

endmodule

// ----- verif/trie_longest_match_transliterator_top_tb.sv -----
`timescale 1ns / 100ps

module trie_longest_match_transliterator_top_tb;
  import tlmt_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [7:0] ch [4];
    int         n;
  } key_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OPC_W-1:0]         in_opcode;
  logic [ADDR_W-1:0]        in_address;
  logic signed [BASE_W-1:0] in_base_value;
  logic [CHECK_W-1:0]       in_check_value;
  logic [BYTE_W-1:0]        in_data;
  logic                     out_valid;
  logic                     out_stall;
  logic [BYTE_W-1:0]        out_out_byte;
  logic                     out_byte_valid;
  logic                     out_last;
  logic                     out_text_done;
  logic [1:0]               out_error;
  int                       fail_count;
  int                       open_count;
  int                       idle_cycles;
  int                       words_sent;
  int                       table_end;
  int                       shadow_len;
  bit                       calm;
  int                       shadow_base [TRIE_ENTRIES];
  int                       shadow_check [TRIE_ENTRIES];
  key_t                     lexicon [$];

  trie_longest_match_transliterator_top DUT (.*);

  trie_longest_match_transliterator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("trie_longest_match_transliterator_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(logic [OPC_W-1:0] op, int a, int bv, int cv, int d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= ADDR_W'(a);
    in_base_value <= BASE_W'(bv);
    in_check_value <= CHECK_W'(cv);
    in_data <= BYTE_W'(d);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (op == OPC_APPEND && shadow_len < TEXT_BYTES) shadow_len++;
    if (op == OPC_CLEAR) shadow_len = 0;
  endtask

  task automatic put_node(int a, int bv, int cv);
    send(OPC_NODE, a, bv, cv, $urandom_range(0, 255));
    shadow_base[a] = bv;
    shadow_check[a] = cv;
  endtask

  task automatic put_byte(opcode_t op, int a, int d);
    send(op, a, $urandom_range(0, 16383), $urandom_range(0, 8191), d);
  endtask

  task automatic put_record(int n, int rewind);
    for (int i = 0; i < n; i++) begin
      put_byte(OPC_TABLE, table_end, $urandom_range(1, 255));
      table_end++;
    end
    put_byte(OPC_TABLE, table_end, 0);
    put_byte(OPC_TABLE, table_end + 1, rewind);
    table_end += 2;
  endtask

  function automatic int terminal_base();
    if ($urandom_range(0, 7) == 0) return -4097 - int'($urandom_range(0, 4095));
    return -(int'($urandom_range(0, table_end - 2)) + 1);
  endfunction

  task automatic add_key(key_t k, int tbase);
    int b, p;
    b = shadow_base[0];
    for (int i = 0; i < k.n; i++) begin
      if (b < 0) return;
      p = b + k.ch[i] + 1;
      if (p >= TRIE_ENTRIES) return;
      if (shadow_check[p] != b) put_node(p, $urandom_range(1, 150), b);
      b = shadow_base[p];
    end
    if (b < 0 || b >= TRIE_ENTRIES) return;
    put_node(b, tbase, b);
    lexicon.push_back(k);
  endtask

  function automatic key_t random_key();
    key_t k;
    k.n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) k.ch[i] = 8'(8'h61 + $urandom_range(0, 5));
    return k;
  endfunction

  function automatic key_t one_char(logic [7:0] c);
    key_t k;
    k.n = 1;
    for (int i = 0; i < 4; i++) k.ch[i] = c;
    return k;
  endfunction

  task automatic append_text(int pieces);
    key_t k;
    for (int i = 0; i < pieces; i++) begin
      if (lexicon.size() > 0 && $urandom_range(0, 9) < 7) begin
        k = lexicon[$urandom_range(0, lexicon.size() - 1)];
        for (int j = 0; j < k.n; j++) put_byte(OPC_APPEND, 0, k.ch[j]);
      end else begin
        case ($urandom_range(0, 3))
          0: put_byte(OPC_APPEND, 0, 8'hC3);
          1: put_byte(OPC_APPEND, 0, 8'hE3);
          2: put_byte(OPC_APPEND, 0, 8'hF0);
          default: put_byte(OPC_APPEND, 0, $urandom_range(0, 255));
        endcase
      end
    end
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OPC_NODE;
    in_address = '0;
    in_base_value = '0;
    in_check_value = '0;
    in_data = '0;
    idle_cycles = 0;
    words_sent = 0;
    table_end = 0;
    shadow_len = 0;
    calm = 1'b1;
    for (int i = 0; i < TRIE_ENTRIES; i++) begin
      shadow_base[i] = 0;
      shadow_check[i] = 8191;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The table holds a string longer than a piece, one whose rewind cannot
    // advance, one with a negative rewind, an empty one, then random strings.
    put_record(40, 0);
    put_record(2, 8'h7F);
    put_record(1, 8'hFF);
    put_record(0, 0);
    while (table_end < 60) put_record($urandom_range(0, 5), $urandom_range(0, 3));

    calm = 1'b0;
    send(OPC_CONVERT, 4095, -8192, 8191, 255);
    put_node(0, 5, 0);
    add_key(one_char(8'h61), -1);
    add_key(one_char(8'h62), -4097);
    add_key(one_char(8'h63), -42);
    add_key(one_char(8'h64), -45);
    put_node(5 + 8'h65 + 1, 4095, 5);
    put_node(5 + 8'h66 + 1, -8192, 5);
    put_byte(OPC_APPEND, 0, 8'h61);
    put_byte(OPC_APPEND, 0, 8'h62);
    put_byte(OPC_APPEND, 0, 8'h63);
    put_byte(OPC_APPEND, 0, 8'h64);
    put_byte(OPC_APPEND, 0, 8'h65);
    put_byte(OPC_APPEND, 0, 8'h65);
    put_byte(OPC_APPEND, 0, 8'h66);
    put_byte(OPC_APPEND, 0, 8'hC3);
    put_byte(OPC_APPEND, 0, 8'hF0);
    repeat (9) send(OPC_CONVERT, 0, 0, 0, 0);
    send(OPC_W'(5), 4095, 8191, 8191, 255);
    send(OPC_CLEAR, 0, 0, 0, 0);

    while (words_sent < 160) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) send(OPC_CLEAR, $urandom_range(0, 4095), 0, 0, 0);
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) add_key(random_key(), terminal_base());
      if ($urandom_range(0, 3) == 0)
        put_node($urandom_range(0, 4095),
                 $urandom_range(0, 1) ? terminal_base() : int'($urandom_range(0, 4095)),
                 $urandom_range(0, 8191));
      if ($urandom_range(0, 5) == 0)
        send(OPC_W'($urandom_range(5, 7)), $urandom_range(0, 4095),
             $urandom_range(0, 16383), $urandom_range(0, 8191), $urandom_range(0, 255));
      append_text($urandom_range(2, 10));
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send(OPC_CONVERT, $urandom_range(0, 4095), $urandom_range(0, 16383),
             $urandom_range(0, 8191), $urandom_range(0, 255));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("trie_longest_match_transliterator_top_tb passed");
    end else begin
      $display("trie_longest_match_transliterator_top_tb failed");
    end
    $finish;
  end

endmodule
